/* sv/brmc_pkg.sv */
// Shared types and constants for the balance robot motor controller.
`default_nettype none
package brmc_pkg;
  localparam int DRIVE_W = 15;
  localparam int RELOAD_W = 16;
  localparam logic signed [DRIVE_W-1:0] MAX_DRIVE = 15'sd10000;
  localparam logic [19:0] RELOAD_NUM = 20'd1000000;
  localparam logic [RELOAD_W-1:0] RELOAD_MAX = 16'hFFFF;
  localparam logic signed [25:0] POS_LIMIT = 26'sd21760000;
  localparam logic signed [15:0] TILT_LIMIT = 16'sd10240;
  localparam logic [8:0] KEEP_W = 9'd179;
  localparam logic [8:0] NEW_W = 9'd77;

  localparam logic [2:0] REG_SETPOINT  = 3'd0;
  localparam logic [2:0] REG_TILT_GAIN = 3'd1;
  localparam logic [2:0] REG_RATE_GAIN = 3'd2;
  localparam logic [2:0] REG_POS_GAIN  = 3'd3;
  localparam logic [2:0] REG_VEL_GAIN  = 3'd4;
  localparam logic [2:0] REG_SPEED_CMD = 3'd5;
  localparam logic [2:0] REG_TURN_L    = 3'd6;
  localparam logic [2:0] REG_TURN_R    = 3'd7;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage
`default_nettype wire

/* sv/balance_robot_motor_controller.sv */
// Top level: cascaded PD balance controller with shared multiplier and serial divider.
// Sequence: nine sequencing steps from input transfer, then two divisions for the step
//   timer reloads, one after the other, before m_tvalid; a zero drive skips its division.
// One input at a time: a new one is taken only once the sequencer and the single divider are done.
// Reset: synchronous, active high; registers to defaults, window and estimators to zero.
// The result register holds while waiting; no new input is taken until the result is written.
`default_nettype none
module balance_robot_motor_controller #(
  parameter int WINDOW_LEN = 20
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [39:0] s_tdata, // tilt_angle[15:0], tilt_rate[35:16], zero pad
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [63:0] m_tdata // left_drive, right_drive, left_dir_pin, right_dir_pin,
                              // left_reload, right_reload
);
  import brmc_pkg::*;
  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  // reciprocal of WINDOW_LEN, exact for magnitudes below 2^21 after a 27-bit shift
  localparam logic [27:0] AVG_RECIP =
    28'(((64'd1 << 27) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  localparam logic [3:0] ST_IDLE = 4'd0, ST_WIN = 4'd1, ST_AVG = 4'd2, ST_EST = 4'd3,
    ST_POS = 4'd4, ST_M0 = 4'd5, ST_M1 = 4'd6, ST_M2 = 4'd7, ST_M3 = 4'd8,
    ST_DRV = 4'd9, ST_DIVL = 4'd10, ST_DIVR = 4'd11, ST_OUT = 4'd12;

  logic signed [15:0] setpoint;
  logic [19:0] tilt_gain;
  logic [11:0] rate_gain, vel_gain;
  logic [15:0] pos_gain;
  logic signed [14:0] speed_cmd, turn_l, turn_r;

  logic signed [15:0] window [WINDOW_LEN];
  logic [IDX_W-1:0] wptr;
  logic signed [20:0] wtotal;
  logic signed [24:0] est;
  logic signed [25:0] pos;
  logic signed [14:0] last_l, last_r;
  logic signed [15:0] angle;
  logic signed [19:0] rate;
  logic signed [15:0] wold;
  logic signed [63:0] acc;
  logic [3:0] state;
  logic [7:0] sub;

  // shared multiplier operands
  logic signed [33:0] ma, mb;
  logic signed [63:0] prod;
  assign prod = 64'(ma) * 64'(mb);

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0; tilt_gain <= 20'd94720; rate_gain <= 12'd256;
      pos_gain <= 16'd1966; vel_gain <= 12'd384; speed_cmd <= '0;
      turn_l <= '0; turn_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:  setpoint <= cfg_data[15:0];
        REG_TILT_GAIN: tilt_gain <= cfg_data;
        REG_RATE_GAIN: rate_gain <= cfg_data[11:0];
        REG_POS_GAIN:  pos_gain <= cfg_data[15:0];
        REG_VEL_GAIN:  vel_gain <= cfg_data[11:0];
        REG_SPEED_CMD: speed_cmd <= cfg_data[14:0];
        REG_TURN_L:    turn_l <= cfg_data[14:0];
        REG_TURN_R:    turn_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // derived combinational values
  logic signed [15:0] mean;
  logic signed [16:0] lsum;
  logic signed [20:0] wtot_new;
  logic signed [27:0] pnew;
  logic signed [63:0] dsum_l, dsum_r;
  logic signed [14:0] drv_l, drv_r;
  logic cut;

  function automatic logic signed [14:0] sat_drive(input logic signed [63:0] s, input logic c);
    logic signed [63:0] t;
    t = (s >= 0) ? (s >>> 24) : -((-s) >>> 24);
    if (c) return '0;
    if (t > 64'(MAX_DRIVE)) return MAX_DRIVE;
    if (t < -64'(MAX_DRIVE)) return -MAX_DRIVE;
    return t[14:0];
  endfunction

  always_comb begin
    lsum = 17'(last_l) + 17'(last_r);
    mean = 16'((lsum < 0) ? -((-lsum) >>> 1) : (lsum >>> 1));
    wtot_new = wtotal - 21'(wold) + 21'(mean);
    pnew = 28'(pos) + 28'(est) + (28'(speed_cmd) <<< 8);
    cut = (angle > TILT_LIMIT) || (angle < -TILT_LIMIT);
    dsum_l = acc + (64'(turn_l) <<< 24);
    dsum_r = acc + (64'(turn_r) <<< 24);
    drv_l = sat_drive(dsum_l, cut);
    drv_r = sat_drive(dsum_r, cut);
  end

  // window total magnitude, then its quotient by WINDOW_LEN
  logic [20:0] aq;

  logic signed [14:0] out_l, out_r;
  logic div_start;
  logic [13:0] div_mag;
  div_ctl_t dctl;
  logic [15:0] dq, rl_l;

  brmc_div u_div (.clk(clk), .rst(rst), .start(div_start), .mag(div_mag),
                  .ctl(dctl), .reload(dq));

  always_comb begin
    div_start = 1'b0;
    div_mag = '0;
    if (state == ST_DRV) begin
      div_start = 1'b1;
      div_mag = 14'((drv_l < 0) ? -drv_l : drv_l);
    end else if (state == ST_DIVL && sub == 8'd1 && !dctl.busy) begin
      div_start = 1'b1;
      div_mag = 14'((out_r < 0) ? -out_r : out_r);
    end
  end

  always_comb begin
    ma = '0; mb = '0;
    unique case (state)
      ST_AVG: begin ma = 34'(aq); mb = 34'(AVG_RECIP); end
      ST_EST: begin ma = 34'(est); mb = 34'(KEEP_W); end
      ST_M0: begin ma = 34'(tilt_gain); mb = 34'(setpoint) - 34'(angle); end
      ST_M1: begin ma = 34'(rate_gain); mb = 34'(rate); end
      ST_M2: begin ma = 34'(pos_gain); mb = 34'(pos); end
      ST_M3: begin ma = 34'(vel_gain); mb = 34'(est); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      wptr <= '0; wtotal <= '0; est <= '0; pos <= '0;
      last_l <= '0; last_r <= '0; sub <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) window[i] <= '0;
    end else begin
      // a new result in ST_OUT takes over the valid flag
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_tvalid && s_tready) begin
          angle <= s_tdata[15:0];
          rate <= s_tdata[35:16];
          wold <= window[wptr];
          state <= ST_WIN;
        end
        ST_WIN: begin
          window[wptr] <= mean;
          wptr <= (wptr == IDX_W'(WINDOW_LEN - 1)) ? '0 : wptr + IDX_W'(1);
          wtotal <= wtot_new;
          aq <= 21'((wtot_new < 0) ? -wtot_new : wtot_new);
          state <= ST_AVG;
        end
        ST_AVG: begin
          // magnitude divide by WINDOW_LEN by reciprocal multiply
          aq <= prod[47:27];
          state <= ST_EST;
        end
        ST_EST: begin
          // floor((179*est + 77*256*avg)/256)
          acc <= prod + (((wtotal < 0) ? -64'(aq) : 64'(aq)) * 64'(NEW_W) <<< 8);
          state <= ST_POS;
        end
        ST_POS: begin
          est <= 25'(acc >>> 8);
          state <= ST_M0;
        end
        ST_M0: begin
          if (pnew > 28'(POS_LIMIT)) pos <= POS_LIMIT;
          else if (pnew < -28'(POS_LIMIT)) pos <= -POS_LIMIT;
          else pos <= 26'(pnew);
          acc <= prod <<< 8;
          state <= ST_M1;
        end
        ST_M1: begin acc <= acc - (prod <<< 8); state <= ST_M2; end
        ST_M2: begin acc <= acc + prod; state <= ST_M3; end
        ST_M3: begin acc <= acc + (prod <<< 8); state <= ST_DRV; end
        ST_DRV: begin
          out_l <= drv_l; out_r <= drv_r;
          last_l <= drv_l; last_r <= drv_r;
          sub <= 8'd1;
          state <= ST_DIVL;
        end
        ST_DIVL: if (sub == 8'd1 && !dctl.busy) begin
          rl_l <= dq;
          sub <= 8'd0;
          state <= ST_DIVR;
        end
        ST_DIVR: if (!dctl.busy && !dctl.start) state <= ST_OUT;
        ST_OUT: if (!m_tvalid || m_tready) begin
          m_tdata <= {dq, rl_l, (out_r > 0), (out_l <= 0), out_r, out_l};
          m_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);

  a_cut: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRV && cut) |=> (out_l == 0 && out_r == 0)) else $error("cut");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[14:0]) <= MAX_DRIVE)) else $error("sat");
  a_pos: assert property (@(posedge clk) disable iff (rst)
    (pos <= POS_LIMIT && pos >= -POS_LIMIT)) else $error("pos");
endmodule
`default_nettype wire

/* sv/brmc_div.sv */
// Restoring serial divider: 1000000 / magnitude, one quotient bit per cycle.
`default_nettype none
module brmc_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [13:0] mag,
  output brmc_pkg::div_ctl_t ctl,
  output logic [15:0] reload
);
  import brmc_pkg::*;
  logic [19:0] num;
  logic [14:0] rem;
  logic [19:0] quo;
  logic [4:0] cnt;
  logic [13:0] dvs;
  logic busy;
  logic [15:0] sh;
  logic [14:0] rem_sh;
  always_comb begin
    sh = {rem, num[19]};
    rem_sh = sh[14:0];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= (mag != 14'd0);
      cnt <= 5'd20;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (start) begin
      num <= RELOAD_NUM;
      rem <= '0;
      quo <= '0;
      dvs <= mag;
    end else if (busy) begin
      num <= {num[18:0], 1'b0};
      if ({1'b0, rem_sh} >= {2'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
        quo <= {quo[18:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[18:0], 1'b0};
      end
    end
  end
  always_comb begin
    ctl.start = start;
    ctl.busy = busy;
    if (dvs == 14'd0 || quo[19:16] != 4'd0) reload = RELOAD_MAX;
    else reload = quo[15:0];
  end
endmodule
`default_nettype wire
